// ===== rtl/cbps_pkg.sv =====
package cbps_pkg;

    // default sizes
    localparam int DEF_MAX_PATTERN = 16;
    localparam int DEF_SKIP_LIMIT  = 255;

    // field and register widths
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 48;
    localparam int COUNT_W   = 32;
    localparam int CFG_W     = 64;
    localparam int PLEN_W    = 5;
    localparam int SKIP_W    = 8;
    localparam int CFG_IDX_W = 2;

    // pattern storage: two 64-bit words of bytes
    localparam int PAT_BYTES = 16;
    localparam int PAT_IDX_W = 4;

    // printable threshold for the skip run
    localparam logic [BYTE_W-1:0] PRINT_MIN = 8'h20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    typedef logic [BYTE_W-1:0] byte_t;

    // upper-case fold, only a..z move
    function automatic byte_t to_upper(input byte_t c);
        byte_t r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7a)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== rtl/cbps_cell.sv =====
module cbps_cell (
    input  logic            clk,
    input  logic            shift_en,
    input  cbps_pkg::byte_t byte_in,
    input  cbps_pkg::byte_t pat_byte,
    input  logic            active,
    output cbps_pkg::byte_t byte_out,
    output logic            hit
);
    import cbps_pkg::*;

    byte_t folded;
    byte_t byte_reg;
    byte_t byte_next;

    // fold once on entry, the neighbor receives the folded byte
    assign folded = to_upper(byte_in);

    // compare the byte that lands here this transaction
    assign hit = !active || (folded == pat_byte);

    always_comb
    begin
        byte_next = byte_reg;
        if (shift_en)
        begin
            byte_next = folded;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;

endmodule

// ===== rtl/caseless_byte_pattern_scanner.sv =====
// channel | direction | handshake            | payload
// in      | to block  | in_valid / in_stall  | data_byte, region_first, byte_addr
// out     | from      | out_valid / out_stall| match_addr, match_total
// cfg     | to block  | cfg_write            | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low: the compare runs across the cell row in
// the cycle the byte is taken, and the result is registered into the output stage.
// A two-entry output stage (output register plus skid) lets input keep flowing
// while a result waits; in_stall rises only when both entries hold results.
// Reset (rst_n, async low) empties the window, ends any skip, zeroes the match
// count and loads the pattern registers with zero bytes and length one.
module caseless_byte_pattern_scanner #(
    parameter int MAX_PATTERN = cbps_pkg::DEF_MAX_PATTERN,
    parameter int SKIP_LIMIT  = cbps_pkg::DEF_SKIP_LIMIT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [cbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbps_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cbps_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           region_first,
    input  logic [cbps_pkg::ADDR_W-1:0]    byte_addr,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cbps_pkg::ADDR_W-1:0]    match_addr,
    output logic [cbps_pkg::COUNT_W-1:0]   match_total
);
    import cbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int JW    = (LEN_W > PAT_IDX_W) ? LEN_W : PAT_IDX_W;
    localparam logic [SKIP_W-1:0] SKIP_LIM = SKIP_W'(SKIP_LIMIT);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_PATTERN);

    // configuration registers
    logic [CFG_W-1:0]  pattern_low_reg, pattern_low_next;
    logic [CFG_W-1:0]  pattern_high_reg, pattern_high_next;
    logic [PLEN_W-1:0] pattern_len_reg, pattern_len_next;

    // scan state
    logic [LEN_W-1:0]   fill_reg, fill_next;
    logic               skipping_reg, skipping_next;
    logic [SKIP_W-1:0]  skip_cnt_reg, skip_cnt_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // output stage and skid
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [COUNT_W-1:0] out_total_reg, out_total_next;
    logic               skid_valid_reg, skid_valid_next;
    logic [ADDR_W-1:0]  skid_addr_reg, skid_addr_next;
    logic [COUNT_W-1:0] skid_total_reg, skid_total_next;

    logic               in_fire;
    logic               skip_active;
    logic               skip_take;
    logic               shift_en;
    logic [LEN_W-1:0]   len_eff;
    logic [LEN_W-1:0]   fill_base;
    logic [LEN_W-1:0]   fill_new;
    logic               all_hit;
    logic               res_valid;
    logic [ADDR_W-1:0]  res_addr;
    logic [COUNT_W-1:0] count_inc;
    logic               out_free;

    byte_t pat_arr [PAT_BYTES];
    byte_t win     [MAX_PATTERN];
    byte_t pat_sel [MAX_PATTERN];
    logic  [MAX_PATTERN-1:0] cell_hit;
    logic  [MAX_PATTERN-1:0] cell_active;

    assign in_fire = in_valid && !in_stall;

    // unpack pattern bytes
    always_comb
    begin
        for (int k = 0; k < PAT_BYTES / 2; k++)
        begin
            pat_arr[k]                 = pattern_low_reg[k*BYTE_W +: BYTE_W];
            pat_arr[k + PAT_BYTES / 2] = pattern_high_reg[k*BYTE_W +: BYTE_W];
        end
    end

    // effective length, clamped to 1..MAX_PATTERN
    always_comb
    begin
        if (32'(pattern_len_reg) > MAX_PATTERN)
        begin
            len_eff = LEN_MAX;
        end
        else if (pattern_len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else
        begin
            len_eff = LEN_W'(pattern_len_reg);
        end
    end

    // skip handling and window fill
    assign skip_active = skipping_reg && !region_first;
    assign skip_take   = skip_active && (skip_cnt_reg < SKIP_LIM) && (data_byte >= PRINT_MIN);
    assign shift_en    = in_fire && !skip_take;
    assign fill_base   = (region_first || skip_active) ? '0 : fill_reg;
    assign fill_new    = (fill_base == LEN_MAX) ? LEN_MAX : fill_base + LEN_W'(1);

    // per-cell pattern byte: newest cell meets the last pattern byte
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            logic [JW-1:0] j;
            j = JW'(len_eff) - JW'(1) - JW'(k);
            cell_active[k] = (JW'(k) < JW'(len_eff));
            if (j < JW'(PAT_BYTES))
            begin
                pat_sel[k] = pat_arr[j[PAT_IDX_W-1:0]];
            end
            else
            begin
                pat_sel[k] = '0;
            end
        end
    end

    // row of window cells
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        byte_t cell_in;
        if (k == 0)
        begin : g_head
            assign cell_in = data_byte;
        end
        else
        begin : g_link
            assign cell_in = win[k-1];
        end
        cbps_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .byte_in  (cell_in),
            .pat_byte (pat_sel[k]),
            .active   (cell_active[k]),
            .byte_out (win[k]),
            .hit      (cell_hit[k])
        );
    end

    assign all_hit   = &cell_hit;
    assign res_valid = shift_en && (fill_new >= len_eff) && all_hit;
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);
    assign res_addr  = byte_addr - ADDR_W'(len_eff) + ADDR_W'(1);

    // scan state update
    always_comb
    begin
        fill_next     = fill_reg;
        skipping_next = skipping_reg;
        skip_cnt_next = skip_cnt_reg;
        count_next    = count_reg;
        if (in_fire)
        begin
            if (skip_take)
            begin
                skip_cnt_next = skip_cnt_reg + SKIP_W'(1);
            end
            else if (res_valid)
            begin
                fill_next     = '0;
                skipping_next = 1'b1;
                skip_cnt_next = '0;
                count_next    = count_inc;
            end
            else
            begin
                fill_next     = fill_new;
                skipping_next = 1'b0;
                skip_cnt_next = '0;
            end
        end
    end

    // configuration writes
    always_comb
    begin
        pattern_low_next  = pattern_low_reg;
        pattern_high_next = pattern_high_reg;
        pattern_len_next  = pattern_len_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_next  = cfg_data;
                REG_PATTERN_HIGH: pattern_high_next = cfg_data;
                REG_PATTERN_LEN:  pattern_len_next  = cfg_data[PLEN_W-1:0];
                default:          pattern_len_next  = pattern_len_reg;
            endcase
        end
    end

    // output register with skid, skid holds the newer result
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_total_next  = out_total_reg;
        skid_valid_next = skid_valid_reg;
        skid_addr_next  = skid_addr_reg;
        skid_total_next = skid_total_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_addr_next   = skid_addr_reg;
                out_total_next  = skid_total_reg;
                skid_valid_next = res_valid;
                skid_addr_next  = res_addr;
                skid_total_next = count_inc;
            end
            else
            begin
                out_valid_next = res_valid;
                out_addr_next  = res_addr;
                out_total_next = count_inc;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_addr_next  = res_addr;
            skid_total_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            pattern_len_reg  <= PLEN_W'(1);
            fill_reg         <= '0;
            skipping_reg     <= 1'b0;
            skip_cnt_reg     <= '0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            pattern_low_reg  <= pattern_low_next;
            pattern_high_reg <= pattern_high_next;
            pattern_len_reg  <= pattern_len_next;
            fill_reg         <= fill_next;
            skipping_reg     <= skipping_next;
            skip_cnt_reg     <= skip_cnt_next;
            count_reg        <= count_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_addr_reg   <= out_addr_next;
        out_total_reg  <= out_total_next;
        skid_addr_reg  <= skid_addr_next;
        skid_total_reg <= skid_total_next;
    end

    assign in_stall    = skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign match_addr  = out_addr_reg;
    assign match_total = out_total_reg;

endmodule

// ===== rtl/cbps_checker.sv =====
module cbps_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [cbps_pkg::ADDR_W-1:0]  match_addr,
    input logic [cbps_pkg::COUNT_W-1:0] match_total
);

    // input backpressure only when a result is already waiting
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without a pending result");

    // every reported match counts at least itself
    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (match_total != '0))
        else $error("match_total is zero on a result");

    // a new result follows an accepted input transaction
    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result appeared without an input transaction");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(match_addr) && $stable(match_total)))
        else $error("stalled result changed");

endmodule

bind caseless_byte_pattern_scanner cbps_checker u_cbps_checker (.*);
